/* rtl/core/swam_pkg.sv */
// ----------------------------------------------------------------------------
// swam_pkg
// Shared types and constants for the sliding window anagram matcher.
// ----------------------------------------------------------------------------
package swam_pkg;

    localparam int KEY_MAX    = 16;
    localparam int LEN_W      = 5;
    localparam int POS_W      = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [POS_W-1:0] MAX_TEXT_LEN = POS_W'(1048576);

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

    localparam logic [63:0]      KEY_LOW_RST  = 64'd7018141374245724520;
    localparam logic [63:0]      KEY_HIGH_RST = 64'd6845554;
    localparam logic [LEN_W-1:0] KEY_LEN_RST  = 5'd11;

    typedef logic [KEY_MAX-1:0][7:0] chars_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       start_of_text;
    } in_item_t;

    typedef struct packed {
        logic             window_match;
        logic [POS_W-1:0] window_start;
        logic [POS_W-1:0] window_end;
        logic [POS_W-1:0] match_total;
    } out_item_t;

    typedef struct packed {
        chars_t           window;
        logic [LEN_W-1:0] len;
        logic             full;
        logic             clear;
        logic [POS_W-1:0] win_start;
        logic [POS_W-1:0] win_end;
    } job_t;

endpackage

/* rtl/core/swam_front.sv */
// ----------------------------------------------------------------------------
// swam_front
// Takes text bytes, folds case, keeps the byte window and position, and
// hands each window snapshot to the queue.
// ----------------------------------------------------------------------------
module swam_front
    import swam_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    input  logic [LEN_W-1:0] len,
    output logic             job_valid,
    input  logic             job_ready,
    output job_t             job
);

    chars_t           window_reg, window_next;
    logic [POS_W-1:0] seen_reg, seen_next;
    logic [POS_W-1:0] seen_base;
    logic [7:0]       ch;
    logic             accept;

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign accept    = in_valid && job_ready;

    always_comb
    begin
        ch = in_data.text_char;
        if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            ch = ch + 8'h20;
        end
        seen_base   = in_data.start_of_text ? '0 : seen_reg;
        seen_next   = (seen_base < MAX_TEXT_LEN) ? seen_base + 1'b1 : seen_base;
        window_next = {window_reg[KEY_MAX-2:0], ch};

        job.window    = window_next;
        job.len       = len;
        job.clear     = in_data.start_of_text;
        job.full      = seen_next >= POS_W'(len);
        job.win_end   = seen_next;
        job.win_start = job.full ? (seen_next - POS_W'(len) + 1'b1) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (accept)
        begin
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg <= window_next;
        end
    end

endmodule

/* rtl/core/swam_queue.sv */
// ----------------------------------------------------------------------------
// swam_queue
// Small FIFO of window snapshots between the front and back ends.
// ----------------------------------------------------------------------------
module swam_queue
    import swam_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/swam_back.sv */
// ----------------------------------------------------------------------------
// swam_back
// Compares each window against the key as multisets in three stages:
// equality matrices, per-byte occurrence counts, then count compare and
// match total in the output register.
// ----------------------------------------------------------------------------
module swam_back
    import swam_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job,
    input  chars_t    key_chars,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int CNT_W = $clog2(KEY_MAX + 1);

    typedef logic [KEY_MAX-1:0] row_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             full;
        logic             clear;
        logic [POS_W-1:0] win_start;
        logic [POS_W-1:0] win_end;
    } meta_t;

    logic      adv;
    logic      s1_valid_reg, s2_valid_reg, out_valid_reg;
    meta_t     s1_meta_reg, s2_meta_reg;
    row_t      eqw_reg [KEY_MAX];
    row_t      eqk_reg [KEY_MAX];
    row_t      eqw_next [KEY_MAX];
    row_t      eqk_next [KEY_MAX];
    cnt_t      cntw_reg [KEY_MAX];
    cnt_t      cntk_reg [KEY_MAX];
    row_t      ok;
    logic      match;
    logic [POS_W-1:0] total_reg, total_next, total_base;
    out_item_t out_reg, out_next;

    function automatic cnt_t popcnt(input row_t r);
        cnt_t s;
        s = '0;
        for (int k = 0; k < KEY_MAX; k++)
        begin
            s = s + cnt_t'(r[k]);
        end
        return s;
    endfunction

    assign adv       = !out_valid_reg || out_ready;
    assign job_ready = adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        for (int i = 0; i < KEY_MAX; i++)
        begin
            for (int j = 0; j < KEY_MAX; j++)
            begin
                eqw_next[i][j] = (job.window[i] == job.window[j]) && (LEN_W'(j) < job.len);
                eqk_next[i][j] = (job.window[i] == key_chars[j]) && (LEN_W'(j) < job.len);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < KEY_MAX; i++)
        begin
            ok[i] = (LEN_W'(i) >= s2_meta_reg.len) || (cntw_reg[i] == cntk_reg[i]);
        end
        match      = s2_meta_reg.full && (&ok);
        total_base = s2_meta_reg.clear ? '0 : total_reg;
        total_next = (match && total_base < MAX_TEXT_LEN) ? total_base + 1'b1 : total_base;

        out_next.window_match = match;
        out_next.window_start = s2_meta_reg.win_start;
        out_next.window_end   = s2_meta_reg.win_end;
        out_next.match_total  = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= job_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_meta_reg.len       <= job.len;
            s1_meta_reg.full      <= job.full;
            s1_meta_reg.clear     <= job.clear;
            s1_meta_reg.win_start <= job.win_start;
            s1_meta_reg.win_end   <= job.win_end;
            s2_meta_reg           <= s1_meta_reg;
            out_reg               <= out_next;
            for (int i = 0; i < KEY_MAX; i++)
            begin
                eqw_reg[i]  <= eqw_next[i];
                eqk_reg[i]  <= eqk_next[i];
                cntw_reg[i] <= popcnt(eqw_reg[i]);
                cntk_reg[i] <= popcnt(eqk_reg[i]);
            end
        end
    end

endmodule

/* rtl/core/sliding_window_anagram_matcher.sv */
// ----------------------------------------------------------------------------
// sliding_window_anagram_matcher
// Flags every text window of key_length bytes that is an anagram of the key.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  text in  | in_valid, in_ready, in_data      | in
//  result   | out_valid, out_ready, out_data   | out
//  config   | cfg_we, cfg_index, cfg_data      | in
//
//  One byte per cycle sustained while the output is ready; a byte passes
//  queue write, equality matrix, occurrence counts, output register.
//  The queue decouples intake from the compare pipeline; a stalled output
//  freezes the compare pipeline while intake continues until the queue fills.
//  Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_window_anagram_matcher
    import swam_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [63:0]      key_low_reg, key_high_reg;
    logic [LEN_W-1:0] key_len_reg;
    logic [LEN_W-1:0] len_eff;
    chars_t           key_chars;
    logic             fj_valid, fj_ready, bj_valid, bj_ready;
    job_t             fj_data, bj_data;

    assign key_chars = {key_high_reg, key_low_reg};

    always_comb
    begin
        if (key_len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (key_len_reg > LEN_W'(KEY_MAX))
        begin
            len_eff = LEN_W'(KEY_MAX);
        end
        else
        begin
            len_eff = key_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= KEY_LOW_RST;
            key_high_reg <= KEY_HIGH_RST;
            key_len_reg  <= KEY_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LEN:  key_len_reg  <= cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    swam_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .len       (len_eff),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job       (fj_data)
    );

    swam_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fj_valid),
        .push_ready (fj_ready),
        .push_data  (fj_data),
        .pop_valid  (bj_valid),
        .pop_ready  (bj_ready),
        .pop_data   (bj_data)
    );

    swam_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job       (bj_data),
        .key_chars (key_chars),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* rtl/core/swam_check.sv */
// ----------------------------------------------------------------------------
// swam_check
// Port-level checks for the anagram matcher, bound to the top level.
// ----------------------------------------------------------------------------
module swam_check
    import swam_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_match_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.window_match |-> out_data.window_start != '0)
        else $error("match reported on a partial window");

    a_start_le_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.window_start != '0 |->
            out_data.window_end >= out_data.window_start)
        else $error("window start beyond window end");

    a_total_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.window_match |-> out_data.match_total != '0)
        else $error("match total zero on a match");

endmodule

bind sliding_window_anagram_matcher swam_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

/* verif/sliding_window_anagram_matcher_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_anagram_matcher_tb
// Streams text bytes through the anagram matcher and checks every result
// against a cycle-free model of the window, byte counts and running totals.
// Covers case folding, out-of-range key lengths, key changes between texts,
// start-of-text clears and an unbroken back-to-back stretch.
// ----------------------------------------------------------------------------

class anagram_scoreboard;

    bit [63:0]                     key_lo;
    bit [63:0]                     key_hi;
    bit [swam_pkg::LEN_W-1:0]      key_len;
    bit [7:0]                      recent [16];
    bit [swam_pkg::POS_W-1:0]      seen;
    bit [swam_pkg::POS_W-1:0]      found;
    int                            win_cnt [256];
    int                            key_cnt [256];
    swam_pkg::out_item_t           expected_windows [$];
    int                            errors;
    int                            checked;

    function new();
        key_lo  = swam_pkg::KEY_LOW_RST;
        key_hi  = swam_pkg::KEY_HIGH_RST;
        key_len = swam_pkg::KEY_LEN_RST;
        seen    = '0;
        found   = '0;
        errors  = 0;
        checked = 0;
    endfunction

    function void write_cfg(logic [swam_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        case (idx)
            swam_pkg::CFG_KEY_LOW:  key_lo  = data;
            swam_pkg::CFG_KEY_HIGH: key_hi  = data;
            swam_pkg::CFG_KEY_LEN:  key_len = data[swam_pkg::LEN_W-1:0];
            default: ;
        endcase
    endfunction

    function int eff_len();
        int n;
        n = key_len;
        if (n < 1) n = 1;
        if (n > swam_pkg::KEY_MAX) n = swam_pkg::KEY_MAX;
        return n;
    endfunction

    function bit [7:0] key_byte(int i);
        if (i < 8) return key_lo[8*i +: 8];
        return key_hi[8*(i-8) +: 8];
    endfunction

    function swam_pkg::out_item_t predict_window(swam_pkg::in_item_t it);
        swam_pkg::out_item_t r;
        bit [7:0]            c;
        int                  len;
        int                  i;
        bit                  full;
        bit                  hit;
        if (it.start_of_text)
        begin
            for (i = 0; i < 16; i++) recent[i] = 8'h00;
            seen  = '0;
            found = '0;
        end
        c = it.text_char;
        if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
        for (i = 15; i > 0; i--) recent[i] = recent[i-1];
        recent[0] = c;
        if (seen < swam_pkg::MAX_TEXT_LEN) seen++;
        len  = eff_len();
        full = (seen >= len);
        hit  = full;
        if (full)
        begin
            for (i = 0; i < len; i++)
            begin
                win_cnt[recent[i]]++;
                key_cnt[key_byte(i)]++;
            end
            // equal sizes, so agreement on every window value is enough
            for (i = 0; i < len; i++)
                if (win_cnt[recent[i]] != key_cnt[recent[i]]) hit = 1'b0;
            for (i = 0; i < len; i++)
            begin
                win_cnt[recent[i]]   = 0;
                key_cnt[key_byte(i)] = 0;
            end
        end
        if (hit && found < swam_pkg::MAX_TEXT_LEN) found++;
        r.window_match = hit;
        r.window_start = full ? swam_pkg::POS_W'(seen - len + 1) : '0;
        r.window_end   = seen;
        r.match_total  = found;
        return r;
    endfunction

    task note_char(swam_pkg::in_item_t it);
        expected_windows.push_back(predict_window(it));
    endtask

    task report(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_window(swam_pkg::out_item_t got);
        swam_pkg::out_item_t want;
        if (expected_windows.size() == 0)
        begin
            report("result with no transaction pending");
            return;
        end
        want = expected_windows.pop_front();
        checked++;
        if (got.window_match !== want.window_match)
            report($sformatf("result %0d window_match got %b want %b",
                             checked, got.window_match, want.window_match));
        if (got.window_start !== want.window_start)
            report($sformatf("result %0d window_start got %0d want %0d",
                             checked, got.window_start, want.window_start));
        if (got.window_end !== want.window_end)
            report($sformatf("result %0d window_end got %0d want %0d",
                             checked, got.window_end, want.window_end));
        if (got.match_total !== want.match_total)
            report($sformatf("result %0d match_total got %0d want %0d",
                             checked, got.match_total, want.match_total));
    endtask

    function int pending();
        return expected_windows.size();
    endfunction

    task final_check();
        if (expected_windows.size() != 0)
            report($sformatf("%0d results never arrived", expected_windows.size()));
    endtask

endclass

module sliding_window_anagram_matcher_tb;
    import swam_pkg::*;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_KEY_LOW;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    anagram_scoreboard sb;
    bit                tx_free    = 1'b0;
    bit                rx_free    = 1'b0;
    int                burst_left = 0;
    int                stall_hold = 0;

    sliding_window_anagram_matcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready) sb.check_window(out_data);
            if (rx_free)
                out_ready <= 1'b1;
            else if (stall_hold == 0)
            begin
                out_ready  <= ($urandom_range(0, 2) != 0);
                stall_hold = $urandom_range(1, 8);
            end
            else
                stall_hold--;
        end
    end

    task automatic push_char(logic [7:0] c, logic sot);
        in_item_t it;
        it.text_char     = c;
        it.start_of_text = sot;
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_char(it);
        if (!tx_free)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
                burst_left--;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_cfg(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] make_key(int kind);
        logic [63:0] w;
        int          i;
        w = '0;
        for (i = 0; i < 8; i++)
            case (kind)
                0: w[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 5));
                1: w[8*i +: 8] = 8'h00;
                2: w[8*i +: 8] = 8'hFF;
                3: w[8*i +: 8] = $urandom_range(0, 1) ? 8'h41 + 8'($urandom_range(0, 25))
                                                      : 8'h61 + 8'($urandom_range(0, 5));
                default: w[8*i +: 8] = 8'($urandom_range(0, 255));
            endcase
        return w;
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] edges [8];
        edges = '{8'h00, 8'hFF, 8'h41, 8'h5A, 8'h40, 8'h5B, 8'h60, 8'h7B};
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            1: return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 5));
            2: return sb.key_byte($urandom_range(0, sb.eff_len() - 1));
            default: return edges[$urandom_range(0, 7)];
        endcase
    endfunction

    task automatic run_random_phase(logic [63:0] lo, logic [63:0] hi, logic [4:0] len, int n);
        int         sent;
        int         i;
        int         j;
        int         klen;
        logic [7:0] perm [16];
        logic [7:0] t;
        wait_idle();
        write_reg(CFG_KEY_LOW, lo);
        write_reg(CFG_KEY_HIGH, hi);
        write_reg(CFG_KEY_LEN, {59'd0, len});
        klen = sb.eff_len();
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                // shuffled copy of the key, letters in random case
                for (i = 0; i < klen; i++) perm[i] = sb.key_byte(i);
                for (i = klen - 1; i > 0; i--)
                begin
                    j       = $urandom_range(0, i);
                    t       = perm[i];
                    perm[i] = perm[j];
                    perm[j] = t;
                end
                for (i = 0; i < klen; i++)
                begin
                    t = perm[i];
                    if (t >= 8'h61 && t <= 8'h7A && $urandom_range(0, 1)) t = t - 8'h20;
                    push_char(t, $urandom_range(0, 79) == 0);
                    sent++;
                end
            end
            else
                repeat ($urandom_range(1, 5))
                begin
                    push_char(noise_char(), $urandom_range(0, 79) == 0);
                    sent++;
                end
        end
    endtask

    initial
    begin
        int         i;
        int         p;
        logic [7:0] c;
        logic [7:0] edge_chars [10];
        sb = new();
        edge_chars = '{8'h00, 8'hFF, 8'h41, 8'h5A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h61, 8'h7A};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default key after reset: fold boundaries, then the key reversed in upper case
        for (i = 0; i < 10; i++) push_char(edge_chars[i], i == 0);
        for (i = sb.eff_len() - 1; i >= 0; i--)
        begin
            c = sb.key_byte(i);
            if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
            push_char(c, 1'b0);
        end
        push_char(8'h80, 1'b1);

        for (p = 0; p < 12; p++)
            case (p)
                0: run_random_phase(make_key(0), make_key(0), 5'd1, 60);
                1: run_random_phase(make_key(0), make_key(0), 5'd16, 90);
                2: run_random_phase(make_key(0), make_key(0), 5'd0, 40);
                3: run_random_phase(make_key(1), make_key(1), 5'd17, 80);
                4: run_random_phase(make_key(2), make_key(2), 5'd31, 60);
                5: run_random_phase(make_key(3), make_key(3), 5'($urandom_range(1, 16)), 60);
                6: run_random_phase(make_key(4), make_key(4), 5'($urandom_range(1, 16)), 60);
                default: run_random_phase(make_key(0), make_key(0),
                                          5'($urandom_range(1, 16)), 60);
            endcase

        // unbroken back-to-back text with the receiver always ready
        wait_idle();
        write_reg(CFG_KEY_LOW, {make_key(4)} & ~64'hFF | 64'h61);
        write_reg(CFG_KEY_LEN, 64'd1);
        tx_free = 1'b1;
        rx_free = 1'b1;
        push_char(8'h61, 1'b1);
        repeat (24) push_char($urandom_range(0, 1) ? 8'h61 : 8'h41, 1'b0);
        push_char(8'h62, 1'b0);
        push_char(8'h61, 1'b0);
        tx_free = 1'b0;
        rx_free = 1'b0;
        push_char(8'h41, 1'b1);
        push_char(8'h63, 1'b0);
        push_char(8'h61, 1'b0);

        wait_idle();
        repeat (12) @(posedge clk);
        sb.final_check();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #60000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/swam_pkg.sv
rtl/core/swam_front.sv
rtl/core/swam_queue.sv
rtl/core/swam_back.sv
rtl/core/sliding_window_anagram_matcher.sv
rtl/core/swam_check.sv
verif/sliding_window_anagram_matcher_tb.sv
